>>> hw/rtl/psfa_pkg.sv
package psfa_pkg;

  localparam int ID_REGS    = 4;
  localparam int NUM_FIELDS = 8;
  localparam int ID_W       = 32;
  localparam int FIELD_W    = 32;
  localparam int SUM_W      = 37;
  localparam int LEN_W      = 7;
  localparam int FLEN_W     = 6;
  localparam int SLOT_W     = 2;
  localparam int CFG_IDX_W  = 3;

  localparam logic [FLEN_W-1:0] FRAME_LENGTH_RST = FLEN_W'(30);

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ID_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ID_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ID_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ID_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 3'd4;

  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } match_t;

endpackage

>>> hw/rtl/per_source_frame_accumulator_core.sv
// a beat that closes a frame is registered in the update stage, and its totals then in the output register
// throughput: one beat per cycle; a closing beat waits only while a stalled result holds
//   the output register, and the input waits with it
// per-source counts and sums live in one state ram, read at acceptance and written back
//   when the update stage advances, with forwarding when back-to-back beats hit the same source
// reset: synchronous, active low; ids to zero, frame length to 30, entry valid flops cleared
module per_source_frame_accumulator_core #(
  parameter int SOURCES   = 4,
  parameter int MAX_FRAME = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [psfa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psfa_pkg::ID_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [psfa_pkg::ID_W-1:0]            in_sender,
  input  psfa_pkg::field_t                     in_field_a,
  input  psfa_pkg::field_t                     in_field_b,
  input  psfa_pkg::field_t                     in_field_c,
  input  psfa_pkg::field_t                     in_field_d,
  input  psfa_pkg::field_t                     in_field_sum,
  input  psfa_pkg::field_t                     in_field_q,
  input  psfa_pkg::field_t                     in_field_x,
  input  psfa_pkg::field_t                     in_field_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [psfa_pkg::SLOT_W-1:0]          out_source_index,
  output psfa_pkg::sum_t                       out_total_a,
  output psfa_pkg::sum_t                       out_total_b,
  output psfa_pkg::sum_t                       out_total_c,
  output psfa_pkg::sum_t                       out_total_d,
  output psfa_pkg::sum_t                       out_total_sum,
  output psfa_pkg::sum_t                       out_total_q,
  output psfa_pkg::sum_t                       out_total_x,
  output psfa_pkg::sum_t                       out_total_y
);

  localparam int SLOTS  = (SOURCES < psfa_pkg::ID_REGS) ? SOURCES : psfa_pkg::ID_REGS;
  localparam int AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW     = $clog2(MAX_FRAME + 1);
  localparam int NF     = psfa_pkg::NUM_FIELDS;
  localparam int SUMS_W = NF * psfa_pkg::SUM_W;
  localparam int RAM_W  = SUMS_W + CW;

  psfa_pkg::match_t             match;
  logic [psfa_pkg::LEN_W-1:0]   eff_len;

  logic                         in_fire;
  logic                         load;
  logic                         fwd_hit;
  logic                         emit;
  logic                         s1_go;
  logic                         wr_en;
  logic [AW-1:0]                rd_addr;
  logic [RAM_W-1:0]             ram_q;
  logic [RAM_W-1:0]             cur;
  logic [RAM_W-1:0]             wr_data;
  logic [CW-1:0]                cur_cnt;
  logic [CW-1:0]                cnt_inc;
  logic [SUMS_W-1:0]            sums_flat;
  psfa_pkg::sum_t               cur_sum [NF];
  psfa_pkg::sum_t               sum_new [NF];
  psfa_pkg::field_t             in_fields [NF];

  logic                         s1_valid_r;
  logic                         s1_valid_nxt;
  logic [AW-1:0]                s1_addr_r;
  logic                         s1_fwd_r;
  logic                         s1_vld_r;
  psfa_pkg::field_t             s1_fields_r [NF];
  logic [SLOTS-1:0]             vld_r;
  logic [RAM_W-1:0]             fwd_data_r;

  logic                         out_valid_r;
  logic [psfa_pkg::SLOT_W-1:0]  out_index_r;
  psfa_pkg::sum_t               out_sum_r [NF];

  psfa_cfg_match #(
    .SLOTS     (SLOTS),
    .MAX_FRAME (MAX_FRAME)
  ) u_cfg_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sender    (in_sender),
    .match     (match),
    .eff_len   (eff_len)
  );

  psfa_ram #(
    .WIDTH (RAM_W),
    .DEPTH (SLOTS)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (wr_data),
    .rd_en   (load),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  assign cfg_ready = 1'b1;

  assign in_fields[0] = in_field_a;
  assign in_fields[1] = in_field_b;
  assign in_fields[2] = in_field_c;
  assign in_fields[3] = in_field_d;
  assign in_fields[4] = in_field_sum;
  assign in_fields[5] = in_field_q;
  assign in_fields[6] = in_field_x;
  assign in_fields[7] = in_field_y;

  // read stage
  assign in_ready = !s1_valid_r || s1_go;
  assign in_fire  = in_valid && in_ready;
  assign load     = in_fire && match.hit;
  assign rd_addr  = AW'(match.slot);
  assign fwd_hit  = wr_en && (s1_addr_r == rd_addr);

  // update stage
  assign cur     = s1_fwd_r ? fwd_data_r : (s1_vld_r ? ram_q : '0);
  assign cur_cnt = cur[RAM_W-1 -: CW];
  assign cnt_inc = cur_cnt + CW'(1);
  assign emit    = psfa_pkg::LEN_W'(cnt_inc) >= eff_len;

  always_comb begin
    for (int f = 0; f < NF; f++) begin
      cur_sum[f] = psfa_pkg::sum_t'(cur[f*psfa_pkg::SUM_W +: psfa_pkg::SUM_W]);
      sum_new[f] = cur_sum[f] + psfa_pkg::SUM_W'(s1_fields_r[f]);
      sums_flat[f*psfa_pkg::SUM_W +: psfa_pkg::SUM_W] = sum_new[f];
    end
  end

  assign s1_go   = s1_valid_r && (!emit || !out_valid_r || out_ready);
  assign wr_en   = s1_go;
  assign wr_data = emit ? '0 : {cnt_inc, sums_flat};

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (wr_en) begin
        vld_r[s1_addr_r] <= 1'b1;
      end
      if (s1_go && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_addr_r <= rd_addr;
      s1_fwd_r  <= fwd_hit;
      s1_vld_r  <= vld_r[rd_addr];
      for (int f = 0; f < NF; f++) begin
        s1_fields_r[f] <= in_fields[f];
      end
    end
    if (wr_en) begin
      fwd_data_r <= wr_data;
    end
    if (s1_go && emit) begin
      out_index_r <= psfa_pkg::SLOT_W'(s1_addr_r);
      for (int f = 0; f < NF; f++) begin
        out_sum_r[f] <= sum_new[f];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_source_index = out_index_r;
  assign out_total_a      = out_sum_r[0];
  assign out_total_b      = out_sum_r[1];
  assign out_total_c      = out_sum_r[2];
  assign out_total_d      = out_sum_r[3];
  assign out_total_sum    = out_sum_r[4];
  assign out_total_q      = out_sum_r[5];
  assign out_total_x      = out_sum_r[6];
  assign out_total_y      = out_sum_r[7];

  a_fwd_capture: assert property (@(posedge clk) disable iff (!rst_n)
    load && fwd_hit |=> s1_fwd_r)
    else $error("forward flag missed on same-source beat");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |-> !in_ready)
    else $error("input taken while update stage stalled");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_go && emit))
    else $error("result raised without a closing beat");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (int'(out_index_r) < SLOTS))
    else $error("result index beyond configured slots");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (int'(cur_cnt) < MAX_FRAME))
    else $error("stored frame count reached frame limit");

endmodule

>>> hw/rtl/psfa_ram.sv
module psfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/psfa_cfg_match.sv
module psfa_cfg_match #(
  parameter int SLOTS     = 4,
  parameter int MAX_FRAME = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [psfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psfa_pkg::ID_W-1:0]           cfg_data,
  input  logic [psfa_pkg::ID_W-1:0]           sender,
  output psfa_pkg::match_t                    match,
  output logic [psfa_pkg::LEN_W-1:0]          eff_len
);

  localparam logic [psfa_pkg::LEN_W-1:0] MAX_LEN = psfa_pkg::LEN_W'(MAX_FRAME);

  logic [psfa_pkg::ID_W-1:0]   id_r [psfa_pkg::ID_REGS];
  logic [psfa_pkg::FLEN_W-1:0] flen_r;
  logic [psfa_pkg::LEN_W-1:0]  flen_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < psfa_pkg::ID_REGS; i++) begin
        id_r[i] <= '0;
      end
      flen_r <= psfa_pkg::FRAME_LENGTH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        psfa_pkg::CFG_SOURCE_ID_0, psfa_pkg::CFG_SOURCE_ID_1,
        psfa_pkg::CFG_SOURCE_ID_2, psfa_pkg::CFG_SOURCE_ID_3: begin
          id_r[cfg_index[psfa_pkg::SLOT_W-1:0]] <= cfg_data;
        end
        psfa_pkg::CFG_FRAME_LENGTH: begin
          flen_r <= cfg_data[psfa_pkg::FLEN_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // lowest slot wins on duplicate ids
  always_comb begin
    match = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (id_r[i] == sender) begin
        match.hit  = 1'b1;
        match.slot = psfa_pkg::SLOT_W'(i);
      end
    end
  end

  assign flen_ext = psfa_pkg::LEN_W'(flen_r);

  always_comb begin
    if (flen_ext == '0) begin
      eff_len = psfa_pkg::LEN_W'(1);
    end else if (flen_ext > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = flen_ext;
    end
  end

endmodule
